// ===== rtl/core/pesp_pkg.sv =====
// Shared types, constants and helpers for the PES packet parser.
// Used by pesp_front, pesp_queue, pesp_out and pes_packet_parser; no dependencies.
package pesp_pkg;

   // Parser phases.
   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_ID    = 4'd1,
      PH_LENHI = 4'd2,
      PH_LENLO = 4'd3,
      PH_EXT   = 4'd4,
      PH_FLAGS = 4'd5,
      PH_HLEN  = 4'd6,
      PH_STAMP = 4'd7,
      PH_HSKIP = 4'd8,
      PH_BODY  = 4'd9
   } phase_type;

   // Stream kinds.
   localparam logic [1:0] KIND_AC3   = 2'd0;
   localparam logic [1:0] KIND_MPA   = 2'd1;
   localparam logic [1:0] KIND_MPV   = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // Stream ids and masks.
   localparam logic [7:0] ID_AC3       = 8'hbd;
   localparam logic [7:0] ID_MPA_MASK  = 8'he0;
   localparam logic [7:0] ID_MPA_BASE  = 8'hc0;
   localparam logic [7:0] ID_MPV_MASK  = 8'hf0;
   localparam logic [7:0] ID_MPV_BASE  = 8'he0;
   localparam logic [23:0] SYNC_CODE   = 24'h000001;

   // Configuration register indexes.
   localparam logic CSR_PREVIEW = 1'b0;
   localparam logic CSR_AUDIO   = 1'b1;

   // Queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [1:0]  stream_kind;
      logic [4:0]  track;
      logic [32:0] pts;
      logic        pts_valid;
      logic        preview_flag;
      logic        first_of_packet;
      logic        last_of_packet;
   } result_type;

   function automatic logic [1:0] kind_of(input logic [7:0] id);
      logic [1:0] kind;
      kind = KIND_OTHER;
      if (id == ID_AC3) begin
         kind = KIND_AC3;
      end else if ((id & ID_MPA_MASK) == ID_MPA_BASE) begin
         kind = KIND_MPA;
      end else if ((id & ID_MPV_MASK) == ID_MPV_BASE) begin
         kind = KIND_MPV;
      end
      return kind;
   endfunction

endpackage

// ===== rtl/core/pesp_front.sv =====
// Front end of the PES packet parser: takes one stream word a cycle while the queue has
// room, tracks the packet structure and classifies each payload word. Depends on pesp_pkg.
module pesp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic                csr_data,
   input  logic                push_ready,
   output logic                push_valid,
   output pesp_pkg::result_type push_data
);

   pesp_pkg::phase_type phase_ff, phase_in;
   logic [23:0] sync_window_ff, sync_window_in;
   logic [7:0]  stream_id_ff, stream_id_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  header_left_ff, header_left_in;
   logic [32:0] stamp_accum_ff, stamp_accum_in;
   logic        stamp_present_ff, stamp_present_in;
   logic [2:0]  stamp_index_ff, stamp_index_in;
   logic        first_pending_ff, first_pending_in;
   logic        preview_mode_ff, preview_mode_in;
   logic        audio_enable_ff, audio_enable_in;

   logic [15:0] left_dec;
   logic [7:0]  hdr_dec;
   logic [15:0] len_full;
   logic [1:0]  kind;
   logic        emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= pesp_pkg::PH_HUNT;
         sync_window_ff   <= '1;
         stream_id_ff     <= '0;
         bytes_left_ff    <= '0;
         header_left_ff   <= '0;
         stamp_accum_ff   <= '0;
         stamp_present_ff <= 1'b0;
         stamp_index_ff   <= '0;
         first_pending_ff <= 1'b1;
         preview_mode_ff  <= 1'b0;
         audio_enable_ff  <= 1'b1;
      end else begin
         phase_ff         <= phase_in;
         sync_window_ff   <= sync_window_in;
         stream_id_ff     <= stream_id_in;
         bytes_left_ff    <= bytes_left_in;
         header_left_ff   <= header_left_in;
         stamp_accum_ff   <= stamp_accum_in;
         stamp_present_ff <= stamp_present_in;
         stamp_index_ff   <= stamp_index_in;
         first_pending_ff <= first_pending_in;
         preview_mode_ff  <= preview_mode_in;
         audio_enable_ff  <= audio_enable_in;
      end
   end

   always_comb begin
      preview_mode_in = preview_mode_ff;
      audio_enable_in = audio_enable_ff;
      if (csr_write) begin
         case (csr_index)
            pesp_pkg::CSR_PREVIEW: preview_mode_in = csr_data;
            pesp_pkg::CSR_AUDIO:   audio_enable_in = csr_data;
            default: ;
         endcase
      end
   end

   assign left_dec = (bytes_left_ff != 16'd0) ? bytes_left_ff - 16'd1 : 16'd0;
   assign hdr_dec  = (header_left_ff != 8'd0) ? header_left_ff - 8'd1 : 8'd0;
   assign len_full = {bytes_left_ff[15:8], data_byte};
   assign kind     = pesp_pkg::kind_of(stream_id_ff);

   always_comb begin
      phase_in         = phase_ff;
      sync_window_in   = sync_window_ff;
      stream_id_in     = stream_id_ff;
      bytes_left_in    = bytes_left_ff;
      header_left_in   = header_left_ff;
      stamp_accum_in   = stamp_accum_ff;
      stamp_present_in = stamp_present_ff;
      stamp_index_in   = stamp_index_ff;
      first_pending_in = first_pending_ff;
      emit             = 1'b0;

      if (take) begin
         case (phase_ff)
            pesp_pkg::PH_ID: begin
               stream_id_in = data_byte;
               phase_in     = pesp_pkg::PH_LENHI;
            end
            pesp_pkg::PH_LENHI: begin
               bytes_left_in = {data_byte, 8'h00};
               phase_in      = pesp_pkg::PH_LENLO;
            end
            pesp_pkg::PH_LENLO: begin
               bytes_left_in = len_full;
               if (kind != pesp_pkg::KIND_OTHER) begin
                  phase_in = pesp_pkg::PH_EXT;
               end else begin
                  first_pending_in = 1'b1;
                  if (len_full == 16'd0) begin
                     phase_in       = pesp_pkg::PH_HUNT;
                     sync_window_in = '1;
                  end else begin
                     phase_in = pesp_pkg::PH_BODY;
                  end
               end
            end
            pesp_pkg::PH_EXT: begin
               bytes_left_in = left_dec;
               phase_in      = pesp_pkg::PH_FLAGS;
            end
            pesp_pkg::PH_FLAGS: begin
               bytes_left_in    = left_dec;
               stamp_present_in = data_byte[7];
               stamp_accum_in   = '0;
               stamp_index_in   = '0;
               phase_in         = pesp_pkg::PH_HLEN;
            end
            pesp_pkg::PH_HLEN: begin
               bytes_left_in  = left_dec;
               header_left_in = data_byte;
               if (stamp_present_ff) begin
                  phase_in = pesp_pkg::PH_STAMP;
               end else if (data_byte != 8'd0) begin
                  phase_in = pesp_pkg::PH_HSKIP;
               end else begin
                  first_pending_in = 1'b1;
                  if (left_dec == 16'd0) begin
                     phase_in       = pesp_pkg::PH_HUNT;
                     sync_window_in = '1;
                  end else begin
                     phase_in = pesp_pkg::PH_BODY;
                  end
               end
            end
            pesp_pkg::PH_STAMP: begin
               bytes_left_in  = left_dec;
               header_left_in = hdr_dec;
               case (stamp_index_ff)
                  3'd0: stamp_accum_in = {data_byte[3:1], 30'd0};
                  3'd1: stamp_accum_in = stamp_accum_ff | (33'(data_byte) << 22);
                  3'd2: stamp_accum_in = stamp_accum_ff | (33'(data_byte[7:1]) << 15);
                  3'd3: stamp_accum_in = stamp_accum_ff | (33'(data_byte) << 7);
                  default: stamp_accum_in = stamp_accum_ff | 33'(data_byte[7:1]);
               endcase
               stamp_index_in = stamp_index_ff + 3'd1;
               if (stamp_index_ff >= 3'd4) begin
                  if (hdr_dec != 8'd0) begin
                     phase_in = pesp_pkg::PH_HSKIP;
                  end else begin
                     first_pending_in = 1'b1;
                     if (left_dec == 16'd0) begin
                        phase_in       = pesp_pkg::PH_HUNT;
                        sync_window_in = '1;
                     end else begin
                        phase_in = pesp_pkg::PH_BODY;
                     end
                  end
               end
            end
            pesp_pkg::PH_HSKIP: begin
               bytes_left_in  = left_dec;
               header_left_in = hdr_dec;
               if (hdr_dec == 8'd0) begin
                  first_pending_in = 1'b1;
                  if (left_dec == 16'd0) begin
                     phase_in       = pesp_pkg::PH_HUNT;
                     sync_window_in = '1;
                  end else begin
                     phase_in = pesp_pkg::PH_BODY;
                  end
               end
            end
            pesp_pkg::PH_BODY: begin
               emit = (kind != pesp_pkg::KIND_OTHER)
                      && ((kind == pesp_pkg::KIND_MPV) || audio_enable_ff);
               if (emit) begin
                  first_pending_in = 1'b0;
               end
               bytes_left_in = left_dec;
               if (left_dec == 16'd0) begin
                  phase_in       = pesp_pkg::PH_HUNT;
                  sync_window_in = '1;
               end
            end
            default: begin
               // Hunting: shift the word into the window and look for a start code.
               sync_window_in = {sync_window_ff[15:0], data_byte};
               if ({sync_window_ff[15:0], data_byte} == pesp_pkg::SYNC_CODE) begin
                  phase_in = pesp_pkg::PH_ID;
               end else begin
                  phase_in = pesp_pkg::PH_HUNT;
               end
            end
         endcase
      end
   end

   assign push_valid                = emit;
   assign push_data.payload_byte    = data_byte;
   assign push_data.stream_kind     = kind;
   assign push_data.track           = (kind == pesp_pkg::KIND_MPA) ? stream_id_ff[4:0] : 5'd0;
   assign push_data.pts             = stamp_present_ff ? stamp_accum_ff : 33'd0;
   assign push_data.pts_valid       = stamp_present_ff;
   assign push_data.preview_flag    = preview_mode_ff;
   assign push_data.first_of_packet = first_pending_ff;
   assign push_data.last_of_packet  = (bytes_left_ff == 16'd1);

`ifndef ASSERT_OFF
   a_emit_in_body: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (phase_ff == pesp_pkg::PH_BODY))
      else $error("payload word emitted outside the packet body");
   a_stamp_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pesp_pkg::PH_STAMP) |-> (stamp_index_ff <= 3'd4))
      else $error("time stamp word index out of range");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("word pushed into a full queue");
`endif

endmodule

// ===== rtl/core/pesp_queue.sv =====
// Short queue between the parser front end and the output stage.
// Depends on pesp_pkg for the result type and depth.
module pesp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  pesp_pkg::result_type push_data,
   output logic                 push_ready,
   input  logic                 pop_ready,
   output logic                 head_valid,
   output pesp_pkg::result_type head_data
);

   pesp_pkg::result_type entry_ff [pesp_pkg::QUEUE_DEPTH];
   logic [pesp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pesp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pesp_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != pesp_pkg::QUEUE_CW'(pesp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = head_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pesp_pkg::QUEUE_CW'(pesp_pkg::QUEUE_DEPTH))
      else $error("queue count above its depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/core/pesp_out.sv =====
// Output stage of the PES packet parser: a result register that drains the queue.
// Depends on pesp_pkg for the result type.
module pesp_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  pesp_pkg::result_type head_data,
   output logic                 pop_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pesp_pkg::result_type rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   pesp_pkg::result_type rsp_data_ff;
   logic                 load;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign load      = head_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_ready) begin
         rsp_valid_in = head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= head_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/pes_packet_parser.sv =====
// PES packet parser: one stream word in, at most one tagged payload word out.
// Use: drive req_data_byte with req_valid; a word is taken when req_valid and
// req_ready are both high. Each taken word advances the start-code hunt, the
// packet header parse or the payload count. Payload words of known streams
// leave on the rsp_ channel with kind, track, time stamp and packet marks.
// Settings go in over csr_valid/csr_index/csr_data: index 0 is preview mode,
// index 1 enables audio; csr_ready is always high, and settings take effect
// on the next taken word.
// Throughput is one word per cycle while req_ready is high. The parser writes a
// taken payload word into the four-entry queue at the edge that takes it; from
// the queue head it moves into the result register that drives rsp_valid.
// When the receiver stalls, the queue fills and req_ready drops only once all
// four entries are in use; header and skipped words keep flowing until then.
// After reset the parser hunts for a start code, preview mode is off and
// audio is enabled; nothing is pending on the result channel.
// Depends on pesp_pkg, pesp_front, pesp_queue and pesp_out.
module pes_packet_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_stream_kind,
   output logic [4:0]  rsp_track,
   output logic [32:0] rsp_pts,
   output logic        rsp_pts_valid,
   output logic        rsp_preview_flag,
   output logic        rsp_first_of_packet,
   output logic        rsp_last_of_packet
);

   logic                 push_valid, push_ready;
   pesp_pkg::result_type push_data;
   logic                 head_valid, pop_ready;
   pesp_pkg::result_type head_data;
   pesp_pkg::result_type rsp_data;
   logic                 take;

   assign req_ready = push_ready;
   assign csr_ready = 1'b1;
   assign take      = req_valid && push_ready;

   pesp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_data_byte),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   pesp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_ready  (pop_ready),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   pesp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop_ready  (pop_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_payload_byte    = rsp_data.payload_byte;
   assign rsp_stream_kind     = rsp_data.stream_kind;
   assign rsp_track           = rsp_data.track;
   assign rsp_pts             = rsp_data.pts;
   assign rsp_pts_valid       = rsp_data.pts_valid;
   assign rsp_preview_flag    = rsp_data.preview_flag;
   assign rsp_first_of_packet = rsp_data.first_of_packet;
   assign rsp_last_of_packet  = rsp_data.last_of_packet;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pes_packet_parser: drives PES stream words, predicts
// the tagged payload words and compares every field. Depends on pesp_pkg and the RTL.
module tb_top;

   localparam int SEG_WORDS     = 280;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_PRINTED   = 100;
   // One bit per random segment, segment 0 in bit 0.
   localparam logic [3:0] SEG_PREVIEW = 4'b0101;
   localparam logic [3:0] SEG_AUDIO   = 4'b1001;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = pesp_pkg::CSR_PREVIEW;
   logic        csr_data = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic [1:0]  rsp_stream_kind;
   logic [4:0]  rsp_track;
   logic [32:0] rsp_pts;
   logic        rsp_pts_valid;
   logic        rsp_preview_flag;
   logic        rsp_first_of_packet;
   logic        rsp_last_of_packet;

   pes_packet_parser i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_stream_kind     (rsp_stream_kind),
      .rsp_track           (rsp_track),
      .rsp_pts             (rsp_pts),
      .rsp_pts_valid       (rsp_pts_valid),
      .rsp_preview_flag    (rsp_preview_flag),
      .rsp_first_of_packet (rsp_first_of_packet),
      .rsp_last_of_packet  (rsp_last_of_packet)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser state as the block should hold it.
   pesp_pkg::phase_type ph = pesp_pkg::PH_HUNT;
   logic [23:0] sync_win = '1;
   logic [7:0]  cur_id = 8'h00;
   logic [15:0] len_left = 16'h0000;
   logic [7:0]  hdr_left = 8'h00;
   logic [32:0] pts_acc = '0;
   logic        pts_seen = 1'b0;
   logic [2:0]  pts_idx = 3'd0;
   logic        first_due = 1'b1;
   logic        cfg_preview = 1'b0;
   logic        cfg_audio = 1'b1;

   pesp_pkg::result_type predicted_words [$];
   logic [7:0]  pending_stream [$];

   int  send_gap_pct = 35;
   int  recv_gap_pct = 62;
   bit  hold_asked = 1'b0;
   bit  long_packet_due = 1'b0;
   int  quiet_cycles = 0;
   int  mismatch_count = 0;
   int  words_sent = 0;
   int  writes_done = 0;
   int  words_checked = 0;
   int  kind_seen [0:3] = '{0, 0, 0, 0};

   // Zero-length packet of an unknown id, a video packet whose PTS is all ones
   // with a header length of zero, then a start code right after the packet end
   // on an audio packet whose length ends with its header.
   logic [7:0] directed_words [0:30] = '{
      8'h00, 8'h00, 8'h01, 8'hBC, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h0A, 8'h81, 8'h80, 8'h00,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
      8'h00, 8'h00, 8'h01, 8'hDF, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00
   };

   function automatic logic [1:0] stream_class(input logic [7:0] id);
      if (id == pesp_pkg::ID_AC3) return pesp_pkg::KIND_AC3;
      if ((id & pesp_pkg::ID_MPA_MASK) == pesp_pkg::ID_MPA_BASE) return pesp_pkg::KIND_MPA;
      if ((id & pesp_pkg::ID_MPV_MASK) == pesp_pkg::ID_MPV_BASE) return pesp_pkg::KIND_MPV;
      return pesp_pkg::KIND_OTHER;
   endfunction

   function automatic void restart_hunt();
      ph = pesp_pkg::PH_HUNT;
      sync_win = '1;
   endfunction

   function automatic void count_down();
      if (len_left != 16'h0000) len_left = len_left - 1'b1;
   endfunction

   function automatic void start_body();
      first_due = 1'b1;
      if (len_left == 16'h0000) restart_hunt();
      else ph = pesp_pkg::PH_BODY;
   endfunction

   function automatic void finish_header();
      if (hdr_left != 8'h00) ph = pesp_pkg::PH_HSKIP;
      else start_body();
   endfunction

   // Advances the parser by one stream word; returns 1 when a payload word leaves.
   function automatic bit parse_word(input logic [7:0] b, output pesp_pkg::result_type r);
      logic [1:0] cls;
      bit emitted;
      emitted = 1'b0;
      r = '0;
      case (ph)
         pesp_pkg::PH_ID: begin
            cur_id = b;
            ph = pesp_pkg::PH_LENHI;
         end
         pesp_pkg::PH_LENHI: begin
            len_left = {b, 8'h00};
            ph = pesp_pkg::PH_LENLO;
         end
         pesp_pkg::PH_LENLO: begin
            len_left[7:0] = b;
            if (stream_class(cur_id) != pesp_pkg::KIND_OTHER) begin
               ph = pesp_pkg::PH_EXT;
            end else begin
               first_due = 1'b1;
               if (len_left == 16'h0000) restart_hunt();
               else ph = pesp_pkg::PH_BODY;
            end
         end
         pesp_pkg::PH_EXT: begin
            count_down();
            ph = pesp_pkg::PH_FLAGS;
         end
         pesp_pkg::PH_FLAGS: begin
            count_down();
            pts_seen = b[7];
            pts_acc = '0;
            pts_idx = 3'd0;
            ph = pesp_pkg::PH_HLEN;
         end
         pesp_pkg::PH_HLEN: begin
            count_down();
            hdr_left = b;
            if (pts_seen) ph = pesp_pkg::PH_STAMP;
            else finish_header();
         end
         pesp_pkg::PH_STAMP: begin
            count_down();
            if (hdr_left != 8'h00) hdr_left = hdr_left - 1'b1;
            // Marker bits are dropped: 3 + 15 + 15 time stamp bits over five words.
            case (pts_idx)
               3'd0: pts_acc = {b[3:1], 30'd0};
               3'd1: pts_acc = pts_acc | {3'd0, b, 22'd0};
               3'd2: pts_acc = pts_acc | {11'd0, b[7:1], 15'd0};
               3'd3: pts_acc = pts_acc | {18'd0, b, 7'd0};
               default: pts_acc = pts_acc | {26'd0, b[7:1]};
            endcase
            pts_idx = pts_idx + 1'b1;
            if (pts_idx >= 3'd5) finish_header();
         end
         pesp_pkg::PH_HSKIP: begin
            count_down();
            if (hdr_left != 8'h00) hdr_left = hdr_left - 1'b1;
            if (hdr_left == 8'h00) start_body();
         end
         pesp_pkg::PH_BODY: begin
            cls = stream_class(cur_id);
            if (cls != pesp_pkg::KIND_OTHER && (cls == pesp_pkg::KIND_MPV || cfg_audio)) begin
               r.payload_byte    = b;
               r.stream_kind     = cls;
               r.track           = (cls == pesp_pkg::KIND_MPA) ? cur_id[4:0] : 5'd0;
               r.pts             = pts_seen ? pts_acc : '0;
               r.pts_valid       = pts_seen;
               r.preview_flag    = cfg_preview;
               r.first_of_packet = first_due;
               r.last_of_packet  = (len_left == 16'h0001);
               first_due = 1'b0;
               emitted = 1'b1;
            end
            count_down();
            if (len_left == 16'h0000) restart_hunt();
         end
         default: begin
            sync_win = {sync_win[15:0], b};
            ph = pesp_pkg::PH_HUNT;
            if (sync_win == pesp_pkg::SYNC_CODE) ph = pesp_pkg::PH_ID;
         end
      endcase
      return emitted;
   endfunction

   // The two payload words of the all-ones PTS packet, read straight off the stream.
   function automatic bit fixed_expectation(input int row, output pesp_pkg::result_type r);
      r = '0;
      r.stream_kind = pesp_pkg::KIND_MPV;
      r.pts         = '1;
      r.pts_valid   = 1'b1;
      case (row)
         20: begin
            r.payload_byte    = 8'h00;
            r.first_of_packet = 1'b1;
            return 1'b1;
         end
         21: begin
            r.payload_byte   = 8'hFF;
            r.last_of_packet = 1'b1;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_payload();
      pesp_pkg::result_type want;
      if (predicted_words.size() == 0) begin
         report_mismatch($sformatf("payload word %h with nothing expected", rsp_payload_byte));
         return;
      end
      want = predicted_words.pop_front();
      words_checked++;
      kind_seen[rsp_stream_kind]++;
      if (rsp_payload_byte !== want.payload_byte)
         report_mismatch($sformatf("payload_byte %h, expected %h",
                                   rsp_payload_byte, want.payload_byte));
      if (rsp_stream_kind !== want.stream_kind)
         report_mismatch($sformatf("stream_kind %0d, expected %0d",
                                   rsp_stream_kind, want.stream_kind));
      if (rsp_track !== want.track)
         report_mismatch($sformatf("track %0d, expected %0d", rsp_track, want.track));
      if (rsp_pts !== want.pts)
         report_mismatch($sformatf("pts %h, expected %h", rsp_pts, want.pts));
      if (rsp_pts_valid !== want.pts_valid)
         report_mismatch($sformatf("pts_valid %b, expected %b", rsp_pts_valid, want.pts_valid));
      if (rsp_preview_flag !== want.preview_flag)
         report_mismatch($sformatf("preview_flag %b, expected %b",
                                   rsp_preview_flag, want.preview_flag));
      if (rsp_first_of_packet !== want.first_of_packet)
         report_mismatch($sformatf("first_of_packet %b, expected %b",
                                   rsp_first_of_packet, want.first_of_packet));
      if (rsp_last_of_packet !== want.last_of_packet)
         report_mismatch($sformatf("last_of_packet %b, expected %b",
                                   rsp_last_of_packet, want.last_of_packet));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (rsp_valid && rsp_ready) check_payload();
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver side: random stalls, plus one long hold-off when asked for.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // Valid stays high between back-to-back words; it drops only during a gap or a drain.
   task automatic send_word(input logic [7:0] w, input bit use_fixed,
                            input pesp_pkg::result_type fixed_r);
      pesp_pkg::result_type predicted;
      bit emits;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      emits = parse_word(w, predicted);
      if (use_fixed) begin
         emits = 1'b1;
         predicted = fixed_r;
      end
      if (emits) predicted_words.push_back(predicted);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_words.size() != 0);
      // Skipped header words leave nothing to wait for, so give the pipeline time.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input logic idx, input logic value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == pesp_pkg::CSR_PREVIEW) cfg_preview = value;
      else cfg_audio = value;
      writes_done++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Appends one packet to the stream: mostly well formed with random content,
   // sometimes junk before it, sometimes a packet cut off after its length.
   task automatic queue_packet();
      logic [7:0]  id;
      logic [7:0]  hdr_len;
      logic [7:0]  flags;
      logic [15:0] len_field;
      int          body_len;
      int          hdr_count;
      int          skip_count;
      int          pick;
      bit          has_pts;
      bit          known;
      bit          long_now;
      long_now = long_packet_due;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         repeat ($urandom_range(1, 4)) pending_stream.push_back(8'($urandom_range(0, 255)));
      if (pick >= 90) pending_stream.push_back(8'h00);
      pending_stream.push_back(8'h00);
      pending_stream.push_back(8'h00);
      pending_stream.push_back(8'h01);
      if (pick >= 95 && !long_now) begin
         pending_stream.push_back(8'($urandom_range(0, 255)));
         pending_stream.push_back(8'h00);
         pending_stream.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 3)) pending_stream.push_back(8'($urandom_range(0, 255)));
         return;
      end

      pick = $urandom_range(0, 99);
      if (long_now) id = pesp_pkg::ID_MPV_BASE | 8'($urandom_range(0, 15));
      else if (pick < 25) id = pesp_pkg::ID_AC3;
      else if (pick < 50) id = pesp_pkg::ID_MPA_BASE | 8'($urandom_range(0, 31));
      else if (pick < 80) id = pesp_pkg::ID_MPV_BASE | 8'($urandom_range(0, 15));
      else do id = 8'($urandom_range(0, 255)); while (stream_class(id) != pesp_pkg::KIND_OTHER);
      known = (stream_class(id) != pesp_pkg::KIND_OTHER);

      if (long_now) body_len = $urandom_range(280, 320);
      else if ($urandom_range(0, 99) < 85) body_len = $urandom_range(0, 12);
      else body_len = $urandom_range(13, 40);
      long_packet_due = 1'b0;

      has_pts = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) == 0) hdr_len = 8'($urandom_range(0, 255));
      else if (has_pts && $urandom_range(0, 4) != 0) hdr_len = 8'($urandom_range(5, 9));
      else hdr_len = 8'($urandom_range(0, 4));
      // Five time stamp words are read even when the header length is shorter.
      skip_count = has_pts ? ((hdr_len > 5) ? hdr_len - 5 : 0) : hdr_len;
      hdr_count = known ? 3 + (has_pts ? 5 : 0) + skip_count : 0;

      len_field = 16'(hdr_count + body_len);
      if (known && !long_now && $urandom_range(0, 9) == 0) begin
         len_field = 16'($urandom_range(0, hdr_count));
         body_len = 0;
      end

      pending_stream.push_back(id);
      pending_stream.push_back(len_field[15:8]);
      pending_stream.push_back(len_field[7:0]);
      if (known) begin
         flags = 8'($urandom_range(0, 127));
         flags[7] = has_pts;
         pending_stream.push_back(8'($urandom_range(0, 255)));
         pending_stream.push_back(flags);
         pending_stream.push_back(hdr_len);
         if (has_pts) repeat (5) pending_stream.push_back(8'($urandom_range(0, 255)));
         repeat (skip_count) pending_stream.push_back(8'($urandom_range(0, 255)));
      end
      repeat (body_len) pending_stream.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin : main
      pesp_pkg::result_type fixed_r;
      bit         use_fixed;
      int         seg;
      int         sent;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < 31; row++) begin
         use_fixed = fixed_expectation(row, fixed_r);
         send_word(directed_words[row], use_fixed, fixed_r);
      end

      for (seg = 0; seg < 4; seg++) begin
         if (seg == 3) begin
            // Finish the stream in progress so the long packet starts from a clean hunt.
            while (pending_stream.size() != 0) send_word(pending_stream.pop_front(), 1'b0, '0);
            while (ph != pesp_pkg::PH_HUNT) send_word(8'hFF, 1'b0, '0);
         end
         wait_for_drain();
         write_setting(pesp_pkg::CSR_PREVIEW, SEG_PREVIEW[seg]);
         write_setting(pesp_pkg::CSR_AUDIO, SEG_AUDIO[seg]);
         send_gap_pct = (seg == 0) ? 35 : (seg == 1) ? 62 : 0;
         recv_gap_pct = (seg == 0) ? 62 : (seg == 1) ? 35 : 0;
         if (seg == 3) long_packet_due = 1'b1;
         for (sent = 0; sent < SEG_WORDS; sent++) begin
            if (pending_stream.size() == 0) queue_packet();
            send_word(pending_stream.pop_front(), 1'b0, '0);
            // Sender pause until every payload word is out, mid-stream.
            if (seg == 2 && sent == 140) wait_for_drain();
            // Long receiver hold-off inside the long video body while the sender keeps going.
            if (seg == 3 && ph == pesp_pkg::PH_BODY && len_left > 16'd200) hold_asked = 1'b1;
         end
      end
      wait_for_drain();

      $display("Sent %0d stream words and %0d register writes; checked %0d payload words",
               words_sent, writes_done, words_checked);
      $display("Payload words by kind: AC-3 %0d, MPEG audio %0d, MPEG video %0d; %0d mismatches",
               kind_seen[pesp_pkg::KIND_AC3], kind_seen[pesp_pkg::KIND_MPA],
               kind_seen[pesp_pkg::KIND_MPV], mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
